[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define CHK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, live during reset as well
`define CHK_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/imuwg_pkg.sv]
`default_nettype none

package imuwg_pkg;

  // window geometry
  localparam int WIN    = 8;
  localparam int SLOT_W = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int CNT_W  = $clog2(WIN + 1);
  localparam int SUM_W  = 16 + $clog2(WIN) + 1;
  localparam int THR_W  = 16 + CNT_W;
  localparam int PROD_W = 2 * SUM_W;
  localparam int SQ_W   = PROD_W + 2;
  localparam int DIVC_W = $clog2(SUM_W + 1);
  localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

  // sample layout
  localparam int SAMPLE_W = 96;

  // fixed time constants in ms
  localparam logic [31:0] COOLDOWN_MS      = 32'd350;
  localparam logic [31:0] MOTION_WIN_MS    = 32'd1500;
  localparam logic [31:0] AWAKE_TIMEOUT_MS = 32'd3000;
  localparam logic [31:0] ROLL_PAIR_MS     = 32'd1200;
  localparam logic [31:0] PULSE_MIN_MS     = 32'd80;
  localparam logic [31:0] PULSE_MAX_MS     = 32'd450;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STILL_GYRO_LIMIT,
    REG_PULSE_MIN_RATE,
    REG_PULSE_MAX_RATE,
    REG_PULSE_END_RATE,
    REG_WAKE_STILL_MS,
    REG_SESSION_TIMEOUT_MS,
    REG_CONFIRM_HOLD_MS,
    REG_SEND_HOLD_MS
  } reg_idx_t;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_CANCEL     = 4'd1,
    EV_WAKE       = 4'd2,
    EV_ARMED      = 4'd3,
    EV_ENERGY     = 4'd4,
    EV_STYLE      = 4'd5,
    EV_PREV       = 4'd6,
    EV_NEXT       = 4'd7,
    EV_CONFIRMING = 4'd8,
    EV_SEND       = 4'd9
  } event_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [14:0] still_lim;
    logic [14:0] pmin;
    logic [14:0] pmax;
    logic [14:0] pend;
    logic [15:0] wake;
    logic [15:0] tout;
    logic [15:0] confirm;
    logic [15:0] send;
  } cfg_t;

  typedef struct packed {
    logic [THR_W-1:0] still_lim;
    logic [THR_W-1:0] pmin;
    logic [THR_W-1:0] pmax;
    logic [THR_W-1:0] pend;
  } thr_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic acc_clr;
    logic acc_en;
  } win_ctl_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
    logic div_init;
    logic div_step;
  } alu_ctl_t;

  // magnitude of a window sum
  function automatic logic [SUM_W-1:0] mag_of(input sum_t x);
    logic [SUM_W-1:0] u;
    u = x;
    mag_of = u[SUM_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

`default_nettype wire

[rtl/imuwg_window.sv]
`default_nettype none

module imuwg_window import imuwg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  win_ctl_t            ctl,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic [SLOT_W-1:0]   rd_addr,
  output logic [CNT_W-1:0]    fill,
  output sum_t                sums [6]
);

  logic [SAMPLE_W-1:0] mem [WIN];
  logic [SAMPLE_W-1:0] rd_q;
  logic [SLOT_W-1:0]   slot;

  // history store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[slot] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // write pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (ctl.wr) begin
      slot <= (32'(slot) == WIN - 1) ? '0 : slot + 1'b1;
      if (32'(fill) < WIN) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // running sums, one history entry per beat of the read port
  always_ff @(posedge clk) begin
    for (int a = 0; a < 6; a++) begin
      if (ctl.acc_clr) begin
        sums[a] <= '0;
      end else if (ctl.acc_en) begin
        sums[a] <= sums[a] + SUM_W'(signed'(rd_q[a*16 +: 16]));
      end
    end
  end

endmodule

`default_nettype wire

[rtl/imuwg_alu.sv]
`default_nettype none

module imuwg_alu import imuwg_pkg::*; (
  input  logic              clk,
  input  alu_ctl_t          ctl,
  input  logic [SUM_W-1:0]  op_a,
  input  logic [SUM_W-1:0]  op_b,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic [PROD_W-1:0] prod,
  output logic [SQ_W-1:0]   sq_acc,
  output logic [SUM_W-1:0]  quot
);

  logic [CNT_W-1:0] rem;
  logic [CNT_W:0]   shifted;
  logic             qbit;
  logic [CNT_W:0]   diff;

  // one restoring division step
  always_comb begin
    shifted = {rem, quot[SUM_W-1]};
    diff    = shifted - {1'b0, divisor};
    qbit    = (shifted >= {1'b0, divisor});
  end

  // shared multiplier, square accumulator and divider
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
    if (ctl.acc_load) begin
      sq_acc <= SQ_W'(prod);
    end else if (ctl.acc_add) begin
      sq_acc <= sq_acc + SQ_W'(prod);
    end
    if (ctl.div_init) begin
      rem  <= '0;
      quot <= dividend;
    end else if (ctl.div_step) begin
      rem  <= qbit ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quot <= {quot[SUM_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

[rtl/imuwg_session.sv]
`default_nettype none

module imuwg_session import imuwg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  thr_t             thr,
  input  logic [CNT_W-1:0] fill,
  input  sum_t             sums [6],
  input  logic [SQ_W-1:0]  sq_acc,
  input  logic [SUM_W-1:0] quot,
  input  logic [31:0]      now,
  input  logic             blocked,
  input  logic             eval_en,
  input  logic             dec_en,
  output event_t           ev,
  output logic             div_sel_roll
);

  typedef enum logic [2:0] {
    SS_IDLE, SS_AWAKE, SS_ARMED, SS_ENERGY, SS_STYLE, SS_COOLDOWN
  } ss_t;

  typedef enum logic [1:0] {AX_NONE, AX_ROLL, AX_VERT} ax_t;

  localparam int PW  = SUM_W + 9;
  localparam int BW  = SQ_W + 7;
  localparam int NNW = 2 * CNT_W;

  // session and pulse state
  ss_t         st, st_next;
  logic [31:0] cool, cool_next;
  logic [31:0] ssp, ssp_next;
  logic [31:0] mm, mm_next;
  logic [31:0] arm, arm_next;
  logic        fr_set, fr_set_next;
  logic        fr_neg, fr_neg_next;
  logic [31:0] frt, frt_next;
  logic        conf, conf_next;
  logic        pon, pon_next;
  logic        pbad, pbad_next;
  ax_t         psel, psel_next;
  logic        pneg, pneg_next;
  logic [31:0] pstart, pstart_next;
  logic [15:0] ppeak, ppeak_next;

  // registered test results
  logic still_f, start_ok, ax0_roll, neg0, bad_now, end_now;

  // eval terms
  logic [SUM_W-1:0] mr, mv, mo, m0, sec0, m1, sec1;
  logic [SUM_W:0]   base0, base1;
  logic [NNW-1:0]   nn;
  logic [BW-1:0]    s100, lo_lim, hi_lim;
  logic             still_c, start_c, bad_c;

  // decision terms
  logic             t_valid, t_on, t_bad, t_neg;
  ax_t              t_sel;
  logic [SUM_W-1:0] peak_upd;
  logic             bad_upd;
  logic [31:0]      dur, now1, s1;
  logic [31:0]      held;
  ss_t              ss;
  logic             do_end;

  // magnitudes and threshold tests
  always_comb begin
    mr    = mag_of(sums[3]);
    mv    = mag_of(sums[4]);
    mo    = mag_of(sums[5]);
    nn    = NNW'(fill) * NNW'(fill);
    s100  = BW'(sq_acc) * BW'(100);
    lo_lim = (BW'(nn) * BW'(81)) << 24;
    hi_lim = (BW'(nn) * BW'(121)) << 24;
    still_c = (CMP_W'(mr) < CMP_W'(thr.still_lim)) &&
              (CMP_W'(mv) < CMP_W'(thr.still_lim)) &&
              (CMP_W'(mo) < CMP_W'(thr.still_lim)) &&
              (s100 >= lo_lim) && (s100 <= hi_lim);
    if (mr >= mv) begin
      m0   = mr;
      sec0 = (mv > mo) ? mv : mo;
    end else begin
      m0   = mv;
      sec0 = (mr > mo) ? mr : mo;
    end
    base0 = (SUM_W+1)'(sec0) + ((SUM_W+1)'(fill) << 4);
    start_c = (CMP_W'(m0) >= CMP_W'(thr.pmin)) && (CMP_W'(m0) <= CMP_W'(thr.pmax)) &&
              (PW'(m0) * PW'(100) >= PW'(base0) * PW'(135));
    m1    = (psel == AX_ROLL) ? mr : mv;
    sec1  = (psel == AX_ROLL) ? mv : mr;
    base1 = (SUM_W+1)'(sec1) + ((SUM_W+1)'(fill) << 4);
    bad_c = (CMP_W'(m1) > CMP_W'(thr.pmax)) ||
            (PW'(m1) * PW'(100) < PW'(base1) * PW'(110));
    div_sel_roll = pon ? (psel == AX_ROLL) : (mr >= mv);
  end

  // pulse tracker outcome for this sample
  always_comb begin
    peak_upd = (quot > SUM_W'(ppeak)) ? quot : SUM_W'(ppeak);
    bad_upd  = pbad | bad_now;
    dur      = now - pstart;
    t_valid  = 1'b0;
    t_on     = pon;
    t_bad    = pbad;
    t_sel    = psel;
    t_neg    = pneg;
    if (!pon) begin
      if (start_ok) begin
        t_on  = 1'b1;
        t_bad = 1'b0;
        t_sel = ax0_roll ? AX_ROLL : AX_VERT;
        t_neg = neg0;
      end
    end else if (!end_now) begin
      t_bad = bad_upd;
    end else begin
      t_valid = !bad_upd && (dur >= PULSE_MIN_MS) && (dur <= PULSE_MAX_MS) &&
                (peak_upd >= SUM_W'(cfg.pmin)) && (peak_upd <= SUM_W'(cfg.pmax));
      t_on  = 1'b0;
      t_bad = 1'b0;
    end
  end

  // session decision
  always_comb begin
    st_next     = st;
    cool_next   = cool;
    ssp_next    = ssp;
    mm_next     = mm;
    arm_next    = arm;
    fr_set_next = fr_set;
    fr_neg_next = fr_neg;
    frt_next    = frt;
    conf_next   = conf;
    pon_next    = pon;
    pbad_next   = pbad;
    psel_next   = psel;
    pneg_next   = pneg;
    pstart_next = pstart;
    ppeak_next  = ppeak;
    ev          = EV_NONE;
    do_end      = 1'b0;
    now1        = now + 32'd1;
    s1          = (ssp == '0) ? now1 : ssp;
    held        = now - mm;
    ss          = st;
    if (st == SS_COOLDOWN && now >= cool) begin
      ss      = SS_IDLE;
      st_next = SS_IDLE;
    end
    if (st == SS_COOLDOWN && now < cool) begin
      ev = EV_NONE;
    end else if (ss != SS_IDLE && blocked) begin
      do_end = 1'b1;
      ev     = EV_CANCEL;
    end else if (ss == SS_IDLE && blocked) begin
      ssp_next = '0;
    end else if (ss == SS_IDLE) begin
      // wake on stillness shortly after motion
      if (!still_f) begin
        ssp_next = '0;
        mm_next  = now1;
      end else if (mm == '0 || (now1 - mm) > MOTION_WIN_MS) begin
        ssp_next = '0;
      end else begin
        ssp_next = s1;
        if ((now1 - s1) >= 32'(cfg.wake)) begin
          st_next  = SS_AWAKE;
          arm_next = now;
          ssp_next = '0;
          ev       = EV_WAKE;
        end
      end
    end else if ((ss inside {SS_ARMED, SS_ENERGY, SS_STYLE}) &&
                 (now - arm) > 32'(cfg.tout)) begin
      do_end = 1'b1;
      ev     = EV_CANCEL;
    end else begin
      // tracker state commits here
      pon_next  = t_on;
      pbad_next = t_bad;
      psel_next = t_sel;
      pneg_next = t_neg;
      if (!pon && start_ok) begin
        pstart_next = now;
        ppeak_next  = quot[15:0];
      end else if (pon) begin
        ppeak_next = peak_upd[15:0];
      end
      case (ss)
        SS_AWAKE: begin
          if ((now - arm) > AWAKE_TIMEOUT_MS) begin
            do_end = 1'b1;
            ev     = EV_CANCEL;
          end else if (!t_valid) begin
            if (fr_set && (now - frt) > ROLL_PAIR_MS) begin
              fr_set_next = 1'b0;
            end
          end else if (t_sel != AX_ROLL) begin
            do_end = 1'b1;
            ev     = EV_CANCEL;
          end else if (!fr_set || (now - frt) > ROLL_PAIR_MS || fr_neg == t_neg) begin
            fr_set_next = 1'b1;
            fr_neg_next = t_neg;
            frt_next    = now;
          end else begin
            st_next     = SS_ARMED;
            arm_next    = now;
            mm_next     = now;
            fr_set_next = 1'b0;
            ev          = EV_ARMED;
          end
        end
        SS_ARMED: begin
          if (t_valid) begin
            if (t_sel != AX_VERT) begin
              do_end = 1'b1;
              ev     = EV_CANCEL;
            end else begin
              st_next   = t_neg ? SS_ENERGY : SS_STYLE;
              mm_next   = now;
              conf_next = 1'b0;
              ev        = t_neg ? EV_ENERGY : EV_STYLE;
            end
          end
        end
        default: begin
          // energy and style modes
          if (t_valid) begin
            if (t_sel != AX_ROLL) begin
              do_end = 1'b1;
              ev     = EV_CANCEL;
            end else begin
              mm_next   = now;
              conf_next = 1'b0;
              ev        = t_neg ? EV_PREV : EV_NEXT;
            end
          end else if (still_f && !t_on) begin
            if (!conf && held >= 32'(cfg.confirm)) begin
              conf_next = 1'b1;
              ev        = EV_CONFIRMING;
            end else if (held >= 32'(cfg.send)) begin
              do_end = 1'b1;
              ev     = EV_SEND;
            end
          end
        end
      endcase
    end
    // session end into cooldown
    if (do_end) begin
      st_next     = SS_COOLDOWN;
      cool_next   = now + COOLDOWN_MS;
      ssp_next    = '0;
      fr_set_next = 1'b0;
      conf_next   = 1'b0;
      pon_next    = 1'b0;
      pbad_next   = 1'b0;
    end
  end

  // state and registered test flags
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= SS_IDLE;
      cool   <= '0;
      ssp    <= '0;
      mm     <= '0;
      arm    <= '0;
      fr_set <= 1'b0;
      fr_neg <= 1'b0;
      frt    <= '0;
      conf   <= 1'b0;
      pon    <= 1'b0;
      pbad   <= 1'b0;
      psel   <= AX_NONE;
      pneg   <= 1'b0;
      pstart <= '0;
      ppeak  <= '0;
    end else if (dec_en) begin
      st     <= st_next;
      cool   <= cool_next;
      ssp    <= ssp_next;
      mm     <= mm_next;
      arm    <= arm_next;
      fr_set <= fr_set_next;
      fr_neg <= fr_neg_next;
      frt    <= frt_next;
      conf   <= conf_next;
      pon    <= pon_next;
      pbad   <= pbad_next;
      psel   <= psel_next;
      pneg   <= pneg_next;
      pstart <= pstart_next;
      ppeak  <= ppeak_next;
    end
    if (eval_en) begin
      still_f  <= still_c;
      start_ok <= start_c;
      ax0_roll <= (mr >= mv);
      neg0     <= (mr >= mv) ? sums[3][SUM_W-1] : sums[4][SUM_W-1];
      bad_now  <= bad_c;
      end_now  <= CMP_W'(m1) < CMP_W'(thr.pend);
    end
  end

endmodule

`default_nettype wire

[rtl/imu_wrist_gesture_recognizer_unit.sv]
// order: write, n-entry sum, multiply, divide, evaluate, decide; n = window fill count (1 to 8)
// one sample in work at a time; its work is set by the window sum over the single
//   history read port, the eight multiply steps and the 20 bit-serial steps of the divider
// a finished result waits in the output register while the next sample is taken; a new
//   result stalls in its last step until the previous one has been taken
// reset: synchronous, clears window fill, session to idle, registers to defaults
`default_nettype none

module imu_wrist_gesture_recognizer_unit import imuwg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_x, accel_y, accel_z, rate_roll, rate_vertical, rate_other, sample_time_ms
  input  logic [127:0]          s_axis_tdata,
  // touch_busy, link_ready, hub_busy
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // gesture_event, zero pad
  output logic [7:0]            m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SUM, S_MUL, S_DIVI, S_DIV, S_EVAL, S_DEC
  } seq_t;

  seq_t               st;
  logic [127:0]       sample;
  logic [2:0]         flags;
  logic [CNT_W-1:0]   k;
  logic [2:0]         step;
  logic [DIVC_W-1:0]  dcnt;
  cfg_t               cfg;
  thr_t               thr;

  win_ctl_t           win_ctl;
  alu_ctl_t           alu_ctl;
  logic [CNT_W-1:0]   fill;
  sum_t               sums [6];
  logic [SUM_W-1:0]   op_a, op_b;
  logic [PROD_W-1:0]  prod;
  logic [SQ_W-1:0]    sq_acc;
  logic [SUM_W-1:0]   quot;
  logic               div_sel_roll;
  logic               eval_en, dec_en, out_free;
  event_t             ev;

  assign s_axis_tready = (st == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.still_lim <= 15'd192;
      cfg.pmin      <= 15'd1920;
      cfg.pmax      <= 15'd4480;
      cfg.pend      <= 15'd960;
      cfg.wake      <= 16'd500;
      cfg.tout      <= 16'd5000;
      cfg.confirm   <= 16'd800;
      cfg.send      <= 16'd1100;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_STILL_GYRO_LIMIT:   cfg.still_lim <= cfg_data[14:0];
        REG_PULSE_MIN_RATE:     cfg.pmin      <= cfg_data[14:0];
        REG_PULSE_MAX_RATE:     cfg.pmax      <= cfg_data[14:0];
        REG_PULSE_END_RATE:     cfg.pend      <= cfg_data[14:0];
        REG_WAKE_STILL_MS:      cfg.wake      <= cfg_data;
        REG_SESSION_TIMEOUT_MS: cfg.tout      <= cfg_data;
        REG_CONFIRM_HOLD_MS:    cfg.confirm   <= cfg_data;
        REG_SEND_HOLD_MS:       cfg.send      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer controls
  always_comb begin
    win_ctl = '0;
    alu_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    eval_en = 1'b0;
    dec_en  = 1'b0;
    case (st)
      S_WRITE: begin
        win_ctl.wr      = 1'b1;
        win_ctl.acc_clr = 1'b1;
      end
      S_SUM: begin
        win_ctl.rd     = (k < fill);
        win_ctl.acc_en = (k != '0);
      end
      S_MUL: begin
        alu_ctl.mul_en   = (step != 3'd7);
        alu_ctl.acc_load = (step == 3'd1);
        alu_ctl.acc_add  = (step == 3'd2) || (step == 3'd3);
        case (step)
          3'd0: begin op_a = mag_of(sums[0]); op_b = mag_of(sums[0]); end
          3'd1: begin op_a = mag_of(sums[1]); op_b = mag_of(sums[1]); end
          3'd2: begin op_a = mag_of(sums[2]); op_b = mag_of(sums[2]); end
          3'd3: begin op_a = SUM_W'(cfg.still_lim); op_b = SUM_W'(fill); end
          3'd4: begin op_a = SUM_W'(cfg.pmin); op_b = SUM_W'(fill); end
          3'd5: begin op_a = SUM_W'(cfg.pmax); op_b = SUM_W'(fill); end
          3'd6: begin op_a = SUM_W'(cfg.pend); op_b = SUM_W'(fill); end
          default: ;
        endcase
      end
      S_DIVI: alu_ctl.div_init = 1'b1;
      S_DIV:  alu_ctl.div_step = 1'b1;
      S_EVAL: eval_en = 1'b1;
      S_DEC:  dec_en  = out_free;
      default: ;
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            st <= S_WRITE;
          end
        end
        S_WRITE: st <= S_SUM;
        S_SUM: begin
          if (k == fill) begin
            st <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == 3'd7) begin
            st <= S_DIVI;
          end
        end
        S_DIVI: st <= S_DIV;
        S_DIV: begin
          if (32'(dcnt) == SUM_W - 1) begin
            st <= S_EVAL;
          end
        end
        S_EVAL: st <= S_DEC;
        S_DEC: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            st            <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // payload, counters and threshold products
  always_ff @(posedge clk) begin
    if (st == S_IDLE && s_axis_tvalid) begin
      sample <= s_axis_tdata;
      flags  <= s_axis_tuser;
    end
    k    <= (st == S_SUM) ? k + 1'b1 : '0;
    step <= (st == S_MUL) ? step + 1'b1 : '0;
    dcnt <= (st == S_DIV) ? dcnt + 1'b1 : '0;
    if (st == S_MUL) begin
      case (step)
        3'd4: thr.still_lim <= prod[THR_W-1:0];
        3'd5: thr.pmin      <= prod[THR_W-1:0];
        3'd6: thr.pmax      <= prod[THR_W-1:0];
        3'd7: thr.pend      <= prod[THR_W-1:0];
        default: ;
      endcase
    end
    if (dec_en) begin
      m_axis_tdata <= {4'b0000, ev};
    end
  end

  imuwg_window u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (win_ctl),
    .wr_data (sample[SAMPLE_W-1:0]),
    .rd_addr (k[SLOT_W-1:0]),
    .fill    (fill),
    .sums    (sums)
  );

  imuwg_alu u_alu (
    .clk      (clk),
    .ctl      (alu_ctl),
    .op_a     (op_a),
    .op_b     (op_b),
    .dividend (div_sel_roll ? mag_of(sums[3]) : mag_of(sums[4])),
    .divisor  (fill),
    .prod     (prod),
    .sq_acc   (sq_acc),
    .quot     (quot)
  );

  imuwg_session u_session (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .thr          (thr),
    .fill         (fill),
    .sums         (sums),
    .sq_acc       (sq_acc),
    .quot         (quot),
    .now          (sample[127:96]),
    .blocked      (flags[0] || !flags[1] || flags[2]),
    .eval_en      (eval_en),
    .dec_en       (dec_en),
    .ev           (ev),
    .div_sel_roll (div_sel_roll)
  );

endmodule

`default_nettype wire

[rtl/imuwg_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module imuwg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [127:0] s_axis_tdata,
  input logic [2:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata,
  input logic         cfg_we,
  input logic [2:0]   cfg_index,
  input logic [15:0]  cfg_data
);

  // one sample in work at a time
  `CHK_ASSERT(a_busy_after_beat, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready after beat")
  // event code within its range
  `CHK_ASSERT(a_event_range, m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd9, "bad event code")
  // pad bits stay clear
  `CHK_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0, "pad bits set")
  // stalled result holds
  `CHK_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  // reset leaves no result and an open input
  `CHK_ASSERT_RST(a_reset_state, rst |=> !m_axis_tvalid && s_axis_tready, "reset state")

endmodule

bind imu_wrist_gesture_recognizer_unit imuwg_checker u_imuwg_checker (.*);

`default_nettype wire
